// ===== rtl/gilbert_elliott_loss_channel_macros.svh =====
// Assertion macros for the loss channel RTL.
`ifndef GILBERT_ELLIOTT_LOSS_CHANNEL_MACROS_SVH
`define GILBERT_ELLIOTT_LOSS_CHANNEL_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define GELC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset.
`define GELC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define GELC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define GELC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/gelc_pkg.sv =====
// Types, codes and defaults shared by the loss channel modules.
`default_nettype none
package gelc_pkg;

    localparam int MAX_BURST_DEF   = 64;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int THRESH_W    = 14;
    localparam int OPCODE_W    = 2;
    localparam int BIN_W       = 6;
    localparam int BURST_OUT_W = 7;
    localparam int BIN_COUNT_W = 32;
    localparam int CFG_IDX_W   = 2;

    localparam int CMD_Q_DEPTH = 2;
    localparam int OUT_Q_DEPTH = 4;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_G2B = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_B2G = CFG_IDX_W'(1);

    typedef enum logic [OPCODE_W-1:0] {
        OP_STEP = 2'd0,
        OP_HOLD = 2'd1,
        OP_READ = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        CMD_PASS = 2'd0,
        CMD_READ = 2'd1,
        CMD_BIN  = 2'd2
    } t_cmd_kind;

    typedef enum logic {
        CLR_SWEEP = 1'b0,
        CLR_DONE  = 1'b1
    } t_clr_state;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [THRESH_W-1:0] random_draw;
        logic [BIN_W-1:0]    bin_index;
    } t_in_item;

    typedef struct packed {
        logic                   channel_good;
        logic [BURST_OUT_W-1:0] burst_length;
        logic [BIN_COUNT_W-1:0] bin_count;
    } t_out_item;

    // Classified item handed from front to back
    typedef struct packed {
        logic                   channel_good;
        logic [BURST_OUT_W-1:0] burst_length;
        t_cmd_kind              kind;
    } t_cmd;

    // Back-end status seen by the top level
    typedef struct packed {
        logic clearing;
        logic cmd_pop;
        logic res_valid;
    } t_back_status;

endpackage
`default_nettype wire

// ===== rtl/gelc_fifo.sv =====
// Small register FIFO with occupancy count.
`default_nettype none
module gelc_fifo
    import gelc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic      [WIDTH-1:0]           o_data,
    output logic                            o_full,
    output logic                            o_empty,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [NW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store entry on push
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gelc_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gelc_ram
    import gelc_pkg::*;
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

// ===== rtl/gelc_front.sv =====
// Front end: thresholds, channel state, burst counter and item classification.
`default_nettype none
module gelc_front
    import gelc_pkg::*;
#(
    parameter int MAX_BURST = MAX_BURST_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [THRESH_W-1:0]          i_cfg_data,
    input  wire logic                         i_accept,
    input  wire t_in_item                     i_in,
    output t_cmd                              o_cmd,
    output logic      [$clog2(MAX_BURST)-1:0] o_addr
);
    localparam int AW = $clog2(MAX_BURST);
    localparam int CW = $clog2(MAX_BURST+1);
    localparam int IW = (AW > BIN_W) ? AW : BIN_W;
    localparam int OW = (CW > BURST_OUT_W) ? CW : BURST_OUT_W;

    logic [THRESH_W-1:0] r_g2b, r_b2g;
    logic                r_good, n_good;
    logic [CW-1:0]       r_burst, n_burst;
    logic [CW-1:0]       burst_inc;
    logic [IW-1:0]       bin_ext;
    logic [OW-1:0]       burst_ext;
    logic                bin_in_range;

    // Take configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g2b <= '0;
            r_b2g <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_G2B: r_g2b <= i_cfg_data;
                CFG_B2G: r_b2g <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign burst_inc    = (r_burst < CW'(MAX_BURST)) ? r_burst + 1'b1 : r_burst;
    assign bin_ext      = IW'(i_in.bin_index);
    assign bin_in_range = (32'(i_in.bin_index) < MAX_BURST);

    // Classify the item and compute the next channel state
    always_comb begin
        n_good     = r_good;
        n_burst    = r_burst;
        o_cmd.kind = CMD_PASS;
        o_addr     = '0;
        case (i_in.opcode)
            OP_STEP: begin
                if (r_good) begin
                    if (i_in.random_draw < r_g2b) begin
                        n_good  = 1'b0;
                        n_burst = burst_inc;
                    end
                end else if (i_in.random_draw < r_b2g) begin
                    n_good  = 1'b1;
                    n_burst = '0;
                    // bin only finished bursts shorter than the saturation point
                    if (r_burst != '0 && r_burst < CW'(MAX_BURST)) begin
                        o_cmd.kind = CMD_BIN;
                        o_addr     = r_burst[AW-1:0];
                    end
                end else begin
                    n_burst = burst_inc;
                end
            end
            OP_HOLD: begin
                if (!r_good) begin
                    n_burst = burst_inc;
                end
            end
            OP_READ: begin
                if (bin_in_range) begin
                    o_cmd.kind = CMD_READ;
                    o_addr     = bin_ext[AW-1:0];
                end
            end
            default: ;
        endcase
        // Report the state after this item
        burst_ext          = OW'(n_burst);
        o_cmd.channel_good = n_good;
        o_cmd.burst_length = burst_ext[BURST_OUT_W-1:0];
    end

    // Advance channel state on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_good  <= 1'b1;
            r_burst <= '0;
        end else if (i_accept) begin
            r_good  <= n_good;
            r_burst <= n_burst;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/gelc_back.sv =====
// Back end: histogram clearing, update and read through the RAM.
`default_nettype none
module gelc_back
    import gelc_pkg::*;
#(
    parameter int MAX_BURST   = MAX_BURST_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cmd_valid,
    input  wire t_cmd                             i_cmd,
    input  wire logic [$clog2(MAX_BURST)-1:0]     i_addr,
    input  wire logic [$clog2(OUT_Q_DEPTH+1)-1:0] i_out_count,
    output t_back_status                          o_status,
    output t_out_item                             o_res
);
    localparam int AW  = $clog2(MAX_BURST);
    localparam int OCW = $clog2(OUT_Q_DEPTH+1);
    localparam int XW  = (COUNT_WIDTH > BIN_COUNT_W) ? COUNT_WIDTH : BIN_COUNT_W;

    t_clr_state           r_clr_state, n_clr_state;
    logic [AW-1:0]        r_clr_addr;
    logic                 clearing;
    logic                 issue;
    logic                 r_b_valid;
    t_cmd                 r_b_cmd;
    logic [AW-1:0]        r_b_addr;
    logic                 r_wr_valid;
    logic [AW-1:0]        r_wr_addr;
    logic [COUNT_WIDTH-1:0] r_wr_data;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] sat_count;
    logic [XW-1:0]        count_ext;

    // Sweep next state: clear each bin once after reset
    always_comb begin
        n_clr_state = r_clr_state;
        case (r_clr_state)
            CLR_SWEEP: begin
                if (r_clr_addr == AW'(MAX_BURST-1)) begin
                    n_clr_state = CLR_DONE;
                end
            end
            CLR_DONE: n_clr_state = CLR_DONE;
            default:  n_clr_state = CLR_SWEEP;
        endcase
    end

    // Sweep outputs
    always_comb begin
        case (r_clr_state)
            CLR_SWEEP: clearing = 1'b1;
            default:   clearing = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_state <= CLR_SWEEP;
            r_clr_addr  <= '0;
        end else begin
            r_clr_state <= n_clr_state;
            if (clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Issue only when the result queue has room for everything in flight
    assign issue = i_cmd_valid && !clearing &&
        ((OCW+1)'(i_out_count) + (OCW+1)'(r_b_valid) < (OCW+1)'(OUT_Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_cmd  <= i_cmd;
        r_b_addr <= i_addr;
    end

    // Forward the previous write when the read raced it
    assign cur_count = (r_wr_valid && r_wr_addr == r_b_addr) ? r_wr_data : rd_data;
    assign sat_count = (&cur_count) ? cur_count : cur_count + 1'b1;

    // Select sweep write or bin update
    always_comb begin
        if (clearing) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = r_b_valid && (r_b_cmd.kind == CMD_BIN);
            wr_addr = r_b_addr;
            wr_data = sat_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_valid <= 1'b0;
        end else begin
            r_wr_valid <= wr_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= wr_addr;
        r_wr_data <= wr_data;
    end

    gelc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BURST)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (i_addr),
        .o_rd_data (rd_data)
    );

    // Build the result; counts show their low 32 bits
    assign count_ext          = XW'(cur_count);
    assign o_res.channel_good = r_b_cmd.channel_good;
    assign o_res.burst_length = r_b_cmd.burst_length;
    assign o_res.bin_count    = (r_b_cmd.kind == CMD_READ) ? count_ext[BIN_COUNT_W-1:0] : '0;

    assign o_status.clearing  = clearing;
    assign o_status.cmd_pop   = issue;
    assign o_status.res_valid = r_b_valid;

endmodule
`default_nettype wire

// ===== rtl/gilbert_elliott_loss_channel.sv =====
// Items pass the command queue, a back-end register and the result queue.
// Throughput: one item per cycle when not stalled; the histogram RAM does one
// read and one write per cycle, with the previous write forwarded to the
// following read. Reset: synchronous, active low; afterwards a clearing pass
// zeroes every bin while full stays high; configuration writes are taken.
`default_nettype none
`include "gilbert_elliott_loss_channel_macros.svh"
module gilbert_elliott_loss_channel
    import gelc_pkg::*;
#(
    parameter int MAX_BURST   = MAX_BURST_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [THRESH_W-1:0]  i_cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire t_in_item             i_in,
    output logic                      empty,
    input  wire logic                 pop,
    output t_out_item                 o_out
);
    localparam int AW   = $clog2(MAX_BURST);
    localparam int CQW  = $bits(t_cmd) + AW;
    localparam int OQW  = $bits(t_out_item);
    localparam int OCW  = $clog2(OUT_Q_DEPTH+1);
    localparam int CQCW = $clog2(CMD_Q_DEPTH+1);

    logic               accept;
    t_cmd               f_cmd;
    logic [AW-1:0]      f_addr;
    logic [CQW-1:0]     cq_out;
    logic               cq_full, cq_empty;
    logic [CQCW-1:0]    cq_count;
    t_cmd               b_cmd;
    logic [AW-1:0]      b_addr;
    t_back_status       b_status;
    t_out_item          b_res;
    logic [OQW-1:0]     oq_out;
    logic               oq_full;
    logic [OCW-1:0]     oq_count;

    assign o_cfg_ready = 1'b1;
    assign full        = cq_full || b_status.clearing;
    assign accept      = push && !full;

    gelc_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_in        (i_in),
        .o_cmd       (f_cmd),
        .o_addr      (f_addr)
    );

    // Decouple classification from histogram work
    gelc_fifo #(
        .WIDTH (CQW),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  ({f_cmd, f_addr}),
        .i_pop   (b_status.cmd_pop),
        .o_data  (cq_out),
        .o_full  (cq_full),
        .o_empty (cq_empty),
        .o_count (cq_count)
    );

    assign b_cmd  = t_cmd'(cq_out[CQW-1:AW]);
    assign b_addr = cq_out[AW-1:0];

    gelc_back #(
        .MAX_BURST   (MAX_BURST),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cq_empty),
        .i_cmd       (b_cmd),
        .i_addr      (b_addr),
        .i_out_count (oq_count),
        .o_status    (b_status),
        .o_res       (b_res)
    );

    // Hold results until the consumer takes them
    gelc_fifo #(
        .WIDTH (OQW),
        .DEPTH (OUT_Q_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_status.res_valid),
        .i_data  (b_res),
        .i_pop   (pop),
        .o_data  (oq_out),
        .o_full  (oq_full),
        .o_empty (empty),
        .o_count (oq_count)
    );

    assign o_out = t_out_item'(oq_out);

    // Credit check keeps the result queue from overflowing
    `GELC_ASSERT_IMP(a_out_room, i_clk, i_rst_n, b_status.res_valid, !oq_full, "result queue overflow")
    // Every issued command yields a result in the following cycle
    `GELC_ASSERT_NEXT(a_issue_result, i_clk, i_rst_n, b_status.cmd_pop, b_status.res_valid, "issued command lost")
    // No command is queued or issued during the clearing pass
    `GELC_ASSERT_IMP(a_clear_idle, i_clk, i_rst_n, b_status.clearing, !b_status.cmd_pop && cq_count == '0, "work during clear")

endmodule
`default_nettype wire
